// ===== src/fpm_pkg.sv =====
// Package for the frame period monitor: constants, configuration type and helpers.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fpm_pkg;

    // In-range frames whose deltas clear the longest figure after reset.
    localparam int unsigned SKIP_FRAMES = 1000;
    // Heartbeat ticks per LED cycle.
    localparam int unsigned BEAT_PERIOD = 100;
    // Fail pattern lights the LED on multiples of this count.
    localparam int unsigned BLINK_STEP = 25;
    // Count at which the normal flash ends.
    localparam int unsigned LED_OFF_COUNT = 98;

    localparam int unsigned STAMP_W = 32;
    localparam int unsigned LIMIT_W = 20;
    localparam int unsigned SKIP_W  = 10;
    localparam int unsigned BEAT_W  = 7;
    localparam int unsigned INDEX_W = 2;

    // Register reset values.
    localparam logic [LIMIT_W-1:0] OUTLIER_RESET = LIMIT_W'(100000);
    localparam logic [LIMIT_W-1:0] TICK_RESET    = LIMIT_W'(10000);

    // Configuration register indexes.
    typedef enum logic [INDEX_W-1:0] {
        REG_FAIL_ALERT   = 2'd0,
        REG_OUTLIER      = 2'd1,
        REG_TICK_PERIOD  = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_index_t;

    // Configuration as seen by the processing units.
    typedef struct packed {
        logic               fail_alert;
        logic [LIMIT_W-1:0] outlier_limit_us;
        logic [LIMIT_W-1:0] tick_period_us;
    } cfg_t;

    // True when a 7-bit count is a multiple of BLINK_STEP.
    function automatic logic is_blink_count(input logic [BEAT_W-1:0] count);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k * BLINK_STEP < (1 << BEAT_W); k++)
        begin
            if (count == BEAT_W'(k * BLINK_STEP))
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

// ===== src/frame_period_monitor_heartbeat.sv =====
// Top level of the frame period monitor: handshakes, configuration and result register.
// Depends on fpm_pkg, fpm_stats and fpm_heartbeat.
`timescale 1ns / 1ps
//
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    timestamp_us
// out      output     out_valid / out_ready  delta_us, average_us, longest_us, led_on
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A word is registered in the input register and then processed through the
// compute stage into the result register, from which its report is offered;
// one word is taken every cycle while the output is not stalled.
// The throughput is set by the single compute stage between the two registers.
// A stalled output holds the result; the input register still takes a word while it
// is empty. Reset clears control and statistics state and restores register defaults.

module frame_period_monitor_heartbeat
    import fpm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [STAMP_W-1:0] timestamp_us,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [STAMP_W-1:0] delta_us,
    output logic [STAMP_W-1:0] average_us,
    output logic [LIMIT_W-1:0] longest_us,
    output logic               led_on,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [INDEX_W-1:0] cfg_index,
    input  logic [LIMIT_W-1:0] cfg_data
);

    cfg_t               cfg_reg;
    logic               in_valid_reg;
    logic [STAMP_W-1:0] stamp_reg;
    logic               out_valid_reg;
    logic [STAMP_W-1:0] delta_reg;
    logic [STAMP_W-1:0] average_reg;
    logic [LIMIT_W-1:0] longest_reg;
    logic               led_reg;
    logic               advance;
    logic [STAMP_W-1:0] delta;
    logic [STAMP_W-1:0] average_next;
    logic [LIMIT_W-1:0] longest_next;
    logic               led_next;

    // Pipeline flow control.
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fail_alert       <= 1'b0;
            cfg_reg.outlier_limit_us <= OUTLIER_RESET;
            cfg_reg.tick_period_us   <= TICK_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_FAIL_ALERT:  cfg_reg.fail_alert       <= cfg_data[0];
                REG_OUTLIER:     cfg_reg.outlier_limit_us <= cfg_data;
                REG_TICK_PERIOD: cfg_reg.tick_period_us   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stamp_reg <= timestamp_us;
        end
    end

    // Processing units.
    fpm_stats u_stats (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .stamp        (stamp_reg),
        .cfg          (cfg_reg),
        .delta        (delta),
        .average_next (average_next),
        .longest_next (longest_next)
    );

    fpm_heartbeat u_heartbeat (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .delta    (delta),
        .cfg      (cfg_reg),
        .led_next (led_next)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            delta_reg   <= delta;
            average_reg <= average_next;
            longest_reg <= longest_next;
            led_reg     <= led_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign delta_us   = delta_reg;
    assign average_us = average_reg;
    assign longest_us = longest_reg;
    assign led_on     = led_reg;

endmodule

// ===== src/fpm_stats.sv =====
// Frame statistics: delta from the previous stamp, halving average and longest delta.
// Depends on fpm_pkg.
`timescale 1ns / 1ps

module fpm_stats
    import fpm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [STAMP_W-1:0] stamp,
    input  cfg_t               cfg,
    output logic [STAMP_W-1:0] delta,
    output logic [STAMP_W-1:0] average_next,
    output logic [LIMIT_W-1:0] longest_next
);

    logic [STAMP_W-1:0] last_stamp_reg;
    logic [STAMP_W-1:0] average_reg;
    logic [LIMIT_W-1:0] longest_reg;
    logic [SKIP_W-1:0]  skip_reg;
    logic [SKIP_W-1:0]  skip_next;
    logic [STAMP_W:0]   average_sum;
    logic               in_range;

    // Modular difference from the previous stamp.
    assign delta = stamp - last_stamp_reg;

    // A delta seeds the average while it is zero; otherwise the sum is halved.
    assign average_sum  = {1'b0, average_reg} + {1'b0, delta};
    assign average_next = (average_reg == '0) ? delta : average_sum[STAMP_W:1];

    // Longest tracking ignores deltas at or above the outlier limit.
    assign in_range = delta < {{(STAMP_W-LIMIT_W){1'b0}}, cfg.outlier_limit_us};

    always_comb
    begin
        skip_next    = skip_reg;
        longest_next = longest_reg;
        if (in_range)
        begin
            if (skip_reg != '0)
            begin
                skip_next    = skip_reg - 1'b1;
                longest_next = '0;
            end
            else if (delta[LIMIT_W-1:0] > longest_reg)
            begin
                longest_next = delta[LIMIT_W-1:0];
            end
        end
    end

    // State advances once per processed word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_stamp_reg <= '0;
            average_reg    <= '0;
            longest_reg    <= '0;
            skip_reg       <= SKIP_W'(SKIP_FRAMES);
        end
        else if (step)
        begin
            last_stamp_reg <= stamp;
            average_reg    <= average_next;
            longest_reg    <= longest_next;
            skip_reg       <= skip_next;
        end
    end

endmodule

// ===== src/fpm_heartbeat.sv =====
// Tick accumulator and heartbeat LED pattern generator.
// Depends on fpm_pkg.
`timescale 1ns / 1ps

module fpm_heartbeat
    import fpm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [STAMP_W-1:0] delta,
    input  cfg_t               cfg,
    output logic               led_next
);

    logic [LIMIT_W-1:0] acc_reg;
    logic [LIMIT_W-1:0] acc_next;
    logic [BEAT_W-1:0]  beat_reg;
    logic [BEAT_W-1:0]  beat_next;
    logic [BEAT_W-1:0]  beat_dec;
    logic               led_reg;
    logic [STAMP_W:0]   tick_sum;
    logic               tick;

    // A tick fires once the accumulated time reaches the period.
    assign tick_sum = {{(STAMP_W+1-LIMIT_W){1'b0}}, acc_reg} + {1'b0, delta};
    assign tick     = tick_sum >= {{(STAMP_W+1-LIMIT_W){1'b0}}, cfg.tick_period_us};
    assign acc_next = tick ? '0 : tick_sum[LIMIT_W-1:0];
    assign beat_dec = beat_reg - 1'b1;

    // Heartbeat step: reload at wrap, optional fail pattern, flash end.
    always_comb
    begin
        beat_next = beat_reg;
        led_next  = led_reg;
        if (tick)
        begin
            beat_next = beat_dec;
            if (beat_dec == '0)
            begin
                led_next  = 1'b1;
                beat_next = BEAT_W'(BEAT_PERIOD);
            end
            if (cfg.fail_alert)
            begin
                led_next = is_blink_count(beat_next);
            end
            if (beat_next == BEAT_W'(LED_OFF_COUNT))
            begin
                led_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            beat_reg <= BEAT_W'(1);
            led_reg  <= 1'b0;
        end
        else if (step)
        begin
            acc_reg  <= acc_next;
            beat_reg <= beat_next;
            led_reg  <= led_next;
        end
    end

endmodule

// ===== bench/frame_period_monitor_heartbeat_tb.sv =====
// Self-checking bench for the frame period monitor: timestamp words in, frame reports out.
// Depends on fpm_pkg and frame_period_monitor_heartbeat; a scoreboard class predicts each report.
`timescale 1ns / 1ps

module frame_period_monitor_heartbeat_tb;
    import fpm_pkg::*;

    // Cycles without any accepted word before the run is declared hung.
    localparam int QUIET_LIMIT = 2000;
    // Length of the deliberate long receiver stall.
    localparam int LONG_HOLD = 80;

    // Timestamp deltas for the opening edge cases, applied with reset settings.
    localparam logic [STAMP_W-1:0] EDGE_STEPS [0:18] = '{
        32'd0, 32'd0, 32'd99999, 32'd100000, 32'd100001,
        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'h8000_0000, 32'd9999,
        32'd1, 32'd0, 32'd5000, 32'd5000, 32'h000F_FFFF,
        32'hAAAA_AAAA, 32'h5555_5555, 32'd2, 32'd3
    };

    typedef struct packed {
        logic [STAMP_W-1:0] delta;
        logic [STAMP_W-1:0] average;
        logic [LIMIT_W-1:0] longest;
        logic               led;
    } frame_report_t;

    // Holds a private copy of the block's settings and statistics, and the
    // queue of frame reports still owed by the block.
    class frame_scoreboard;
        logic               cfg_fail_alert;
        logic [LIMIT_W-1:0] cfg_outlier;
        logic [LIMIT_W-1:0] cfg_tick;

        logic [STAMP_W-1:0] prev_stamp;
        logic [STAMP_W-1:0] avg_us;
        logic [LIMIT_W-1:0] peak_us;
        logic [SKIP_W-1:0]  skip_left;
        logic [LIMIT_W-1:0] tick_sum;
        logic [BEAT_W-1:0]  beat;
        logic               led;

        frame_report_t      expected_frames[$];
        int                 errors;

        function new();
            cfg_fail_alert = 1'b0;
            cfg_outlier    = OUTLIER_RESET;
            cfg_tick       = TICK_RESET;
            prev_stamp     = '0;
            avg_us         = '0;
            peak_us        = '0;
            skip_left      = SKIP_W'(SKIP_FRAMES);
            tick_sum       = '0;
            beat           = BEAT_W'(1);
            led            = 1'b0;
            errors         = 0;
        endfunction

        function void write_reg(input logic [INDEX_W-1:0] idx, input logic [LIMIT_W-1:0] value);
            case (idx)
                REG_FAIL_ALERT:  cfg_fail_alert = value[0];
                REG_OUTLIER:     cfg_outlier = value;
                REG_TICK_PERIOD: cfg_tick = value;
                default:         ;
            endcase
        endfunction

        // Advances the statistics by one timestamp and queues the report it should give.
        function void predict_frame(input logic [STAMP_W-1:0] stamp);
            frame_report_t    want;
            logic [STAMP_W:0] wide;
            want.delta = stamp - prev_stamp;
            prev_stamp = stamp;

            // The average is seeded while it is zero, then halves towards each delta.
            if (avg_us == '0)
            begin
                avg_us = want.delta;
            end
            else
            begin
                wide = {1'b0, avg_us} + {1'b0, want.delta};
                avg_us = wide[STAMP_W:1];
            end

            // Only deltas below the outlier limit count, and the first ones only clear the peak.
            if (want.delta < STAMP_W'(cfg_outlier))
            begin
                if (skip_left != '0)
                begin
                    skip_left = skip_left - 1'b1;
                    peak_us = '0;
                end
                else if (want.delta > STAMP_W'(peak_us))
                begin
                    peak_us = want.delta[LIMIT_W-1:0];
                end
            end

            // Tick accumulator; each tick steps the heartbeat count.
            wide = {1'b0, STAMP_W'(tick_sum)} + {1'b0, want.delta};
            if (wide >= (STAMP_W + 1)'(cfg_tick))
            begin
                tick_sum = '0;
                beat = beat - 1'b1;
                if (beat == '0)
                begin
                    led = 1'b1;
                    beat = BEAT_W'(BEAT_PERIOD);
                end
                if (cfg_fail_alert)
                begin
                    led = ((beat % BLINK_STEP) == 0);
                end
                if (beat == BEAT_W'(LED_OFF_COUNT))
                begin
                    led = 1'b0;
                end
            end
            else
            begin
                tick_sum = wide[LIMIT_W-1:0];
            end

            want.average = avg_us;
            want.longest = peak_us;
            want.led     = led;
            expected_frames.push_back(want);
        endfunction

        task report(input string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_frame(input frame_report_t got);
            frame_report_t want;
            if (expected_frames.size() == 0)
            begin
                report($sformatf("report with delta %0d arrived with no frame pending", got.delta));
                return;
            end
            want = expected_frames.pop_front();
            if (got.delta !== want.delta)
                report($sformatf("delta_us got %0d want %0d", got.delta, want.delta));
            if (got.average !== want.average)
                report($sformatf("average_us got %0d want %0d", got.average, want.average));
            if (got.longest !== want.longest)
                report($sformatf("longest_us got %0d want %0d", got.longest, want.longest));
            if (got.led !== want.led)
                report($sformatf("led_on got %0b want %0b", got.led, want.led));
        endtask

        task report_leftovers();
            frame_report_t want;
            while (expected_frames.size() != 0)
            begin
                want = expected_frames.pop_front();
                report($sformatf("report with delta %0d never arrived", want.delta));
            end
        endtask

        function int pending();
            return expected_frames.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [STAMP_W-1:0] timestamp_us;
    logic               out_valid;
    logic               out_ready;
    logic [STAMP_W-1:0] delta_us;
    logic [STAMP_W-1:0] average_us;
    logic [LIMIT_W-1:0] longest_us;
    logic               led_on;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [INDEX_W-1:0] cfg_index;
    logic [LIMIT_W-1:0] cfg_data;

    frame_scoreboard    board = new();
    logic [STAMP_W-1:0] stamp_cursor = '0;
    int                 quiet_cycles = 0;
    int                 tx_idle_pct = 0;
    int                 rx_idle_pct = 0;
    bit                 hold_request = 1'b0;

    frame_period_monitor_heartbeat dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .timestamp_us (timestamp_us),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .delta_us     (delta_us),
        .average_us   (average_us),
        .longest_us   (longest_us),
        .led_on       (led_on),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 100 MHz clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sample every handshake at the rising edge and feed the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                board.write_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                board.predict_frame(timestamp_us);
            if (out_valid && out_ready)
                board.check_frame({delta_us, average_us, longest_us, led_on});
            if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: the run is hung if no word moves on any channel for too long.
    initial
    begin
        @(posedge clk);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: random stall bursts, plus one long stall on request.
    initial
    begin
        int burst;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct)
            begin
                burst = $urandom_range(1, 14);
                out_ready <= 1'b0;
                repeat (burst - 1) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Next timestamp: mostly short frame periods, some zero, some at or next to the outlier
    // limit, some long, and now and then a jump to an arbitrary time.
    function automatic logic [STAMP_W-1:0] advance_stamp(input logic [LIMIT_W-1:0] limit);
        int                 pick;
        logic [STAMP_W-1:0] step;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            step = $urandom_range(0, 15);
        else if (pick < 80)
            step = $urandom_range(16, 3000);
        else if (pick < 86)
            step = STAMP_W'(limit) + $urandom_range(0, 2) - 1;
        else if (pick < 91)
            step = '0;
        else
            step = $urandom_range(0, 20'hFFFFF);
        if (pick >= 96)
            stamp_cursor = $urandom;
        else
            stamp_cursor = stamp_cursor + step;
        return stamp_cursor;
    endfunction

    // Offer one timestamp word, possibly after a random gap, and wait for acceptance.
    task automatic offer_stamp(input logic [STAMP_W-1:0] stamp);
        int gap;
        if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            gap = $urandom_range(1, 14);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        timestamp_us <= stamp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Stop sending and wait until every report owed has come back.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(input reg_index_t idx, input logic [LIMIT_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One phase: settle, program all registers, then stream random timestamps.
    task automatic run_phase(input logic fail, input logic [LIMIT_W-1:0] limit,
                             input logic [LIMIT_W-1:0] period, input int count,
                             input int tx_pct, input int rx_pct,
                             input int hold_at, input int pause_at);
        logic [LIMIT_W-1:0] noise;
        settle();
        noise = LIMIT_W'($urandom);
        write_config(REG_FAIL_ALERT, {noise[LIMIT_W-1:1], fail});
        write_config(REG_OUTLIER, limit);
        write_config(REG_TICK_PERIOD, period);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int n = 0; n < count; n++)
        begin
            if (n == hold_at)
                hold_request = 1'b1;
            if (n == pause_at)
                settle();
            offer_stamp(advance_stamp(limit));
        end
    endtask

    // Main sequence.
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        timestamp_us = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_FAIL_ALERT;
        cfg_data = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // Edge cases under reset settings: zero deltas, the outlier boundary,
        // wrap-around, full-scale deltas and a tick landing exactly on the period.
        foreach (EDGE_STEPS[k])
        begin
            stamp_cursor = stamp_cursor + EDGE_STEPS[k];
            offer_stamp(stamp_cursor);
        end

        // Fast ticks with the receiver stalled long enough to back up the input.
        run_phase(1'b0, 20'd100000, 20'd1, 200, 20, 20, 100, -1);
        // The spare register index must be harmless.
        settle();
        write_config(REG_UNUSED, 20'hFFFFF);
        // Zero limit and zero period: nothing counts, every frame ticks.
        run_phase(1'b1, 20'd0, 20'd0, 30, 30, 0, -1, -1);
        // Smallest nonzero limit, largest period.
        run_phase(1'b0, 20'd1, 20'hFFFFF, 30, 0, 30, -1, -1);
        // Widest limit, very slow ticks, with a full drain midway.
        run_phase(1'b1, 20'hFFFFF, 20'd1000000, 200, 10, 10, -1, 100);
        run_phase(1'b0, 20'd1000000, 20'd5, 220, 25, 25, -1, -1);
        // Closing stretch at full rate on both sides.
        run_phase(1'b1, 20'd3000, 20'd2, 150, 0, 0, -1, -1);

        settle();
        repeat (8) @(posedge clk);
        board.report_leftovers();
        if (board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
